// ===== src/frd_pkg.sv =====
package frd_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] TYPE_END_REQUEST = 8'd3;
  localparam logic [7:0] TYPE_STDOUT      = 8'd6;
  localparam logic [7:0] TYPE_STDERR      = 8'd7;

  localparam logic [15:0] STATUS_OFFSET = 16'd4;

  typedef enum logic [1:0] {
    KIND_STDOUT = 2'd0,
    KIND_STDERR = 2'd1,
    KIND_END    = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last_of_record;
  } event_t;

endpackage

// ===== src/frd_parser.sv =====
module frd_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            queue_full,
  output logic            push,
  output frd_pkg::event_t push_event
);
  import frd_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_CONTENT = 2'd1,
    PH_PADDING = 2'd2
  } phase_t;

  phase_t      phase;
  logic [2:0]  header_index;
  logic [7:0]  record_type;
  logic [7:0]  length_high;
  logic [15:0] content_length;
  logic [15:0] content_position;
  logic [7:0]  padding_left;

  logic        accept;
  logic        last;
  logic [7:0]  padding_dec;

  assign in_ready    = !queue_full;
  assign accept      = in_valid && in_ready;
  assign last        = ({1'b0, content_position} + 17'd1) == {1'b0, content_length};
  assign padding_dec = padding_left - 8'd1;

  // classify the current beat into at most one result
  always_comb begin
    push       = 1'b0;
    push_event = '{kind: KIND_STDOUT, data: in_byte, last_of_record: 1'b0};
    if (accept && phase == PH_CONTENT) begin
      if (record_type == TYPE_STDOUT || record_type == TYPE_STDERR) begin
        push = 1'b1;
        push_event.kind = (record_type == TYPE_STDOUT) ? KIND_STDOUT : KIND_STDERR;
        push_event.last_of_record = last;
      end else if (record_type == TYPE_END_REQUEST && content_position == STATUS_OFFSET) begin
        push = 1'b1;
        push_event.kind = KIND_END;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      header_index     <= 3'd0;
      record_type      <= 8'd0;
      length_high      <= 8'd0;
      content_length   <= 16'd0;
      content_position <= 16'd0;
      padding_left     <= 8'd0;
    end else if (accept) begin
      case (phase)
        PH_CONTENT: begin
          content_position <= content_position + 16'd1;
          if (last) begin
            phase <= (padding_left != 8'd0) ? PH_PADDING : PH_HEADER;
          end
        end
        PH_PADDING: begin
          padding_left <= padding_dec;
          if (padding_dec == 8'd0) begin
            phase <= PH_HEADER;
          end
        end
        default: begin
          case (header_index)
            3'd1: record_type <= in_byte;
            3'd4: length_high <= in_byte;
            3'd5: content_length <= {length_high, in_byte};
            3'd6: padding_left <= in_byte;
            default: ;
          endcase
          if (header_index == 3'd7) begin
            header_index     <= 3'd0;
            content_position <= 16'd0;
            if (content_length != 16'd0) begin
              phase <= PH_CONTENT;
            end else begin
              phase <= (padding_left != 8'd0) ? PH_PADDING : PH_HEADER;
            end
          end else begin
            header_index <= header_index + 3'd1;
            phase        <= PH_HEADER;
          end
        end
      endcase
    end
  end

endmodule

// ===== src/frd_queue.sv =====
module frd_queue #(
  parameter int Depth = frd_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  frd_pkg::event_t push_event,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output frd_pkg::event_t head_event
);
  import frd_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  event_t          mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  logic do_push;
  logic do_pop;

  assign full       = count == CntW'(Depth);
  assign head_valid = count != '0;
  assign head_event = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_event;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/frd_emitter.sv =====
module frd_emitter (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  frd_pkg::event_t head_event,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output frd_pkg::event_t out_event
);
  import frd_pkg::*;

  logic load;

  // output register refills whenever it is empty or being drained
  assign load = !out_valid || out_ready;
  assign pop  = load && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_event <= head_event;
    end
  end

endmodule

// ===== src/fastcgi_response_deframer.sv =====
// a result passes from the parser into the event queue, then into the output register, before it appears on m_axis
// throughput: one byte per cycle while the queue is not full, no bubbles at header, content or padding boundaries
// the event queue between parser and output register absorbs m_axis stalls;
// s_axis_tready drops only while that queue is full
// reset: synchronous active-high rst returns the parser to the first header byte
// and empties the queue and output register
module fastcgi_response_deframer #(
  parameter int QueueDepth = frd_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] stream_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] data
  output logic [1:0] m_axis_tuser,   // [1:0] kind
  output logic       m_axis_tlast    // last_of_record
);
  import frd_pkg::*;

  logic   queue_full;
  logic   push;
  event_t push_event;
  logic   pop;
  logic   head_valid;
  event_t head_event;
  event_t out_event;

  frd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .queue_full (queue_full),
    .push       (push),
    .push_event (push_event)
  );

  frd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_event (push_event),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_event (head_event)
  );

  frd_emitter u_emitter (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_event (head_event),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_event  (out_event)
  );

  assign m_axis_tdata = out_event.data;
  assign m_axis_tuser = out_event.kind;
  assign m_axis_tlast = out_event.last_of_record;

endmodule

// ===== verif/tb_fastcgi_response_deframer.sv =====
module tb_fastcgi_response_deframer;
  import frd_pkg::*;

  localparam int TIMEOUT_CYCLES = 400000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RANDOM_BYTES   = 1300;

  // header byte positions that carry fields, and the last header byte
  localparam logic [2:0] HDR_TYPE   = 3'd1;
  localparam logic [2:0] HDR_LEN_HI = 3'd4;
  localparam logic [2:0] HDR_LEN_LO = 3'd5;
  localparam logic [2:0] HDR_PAD    = 3'd6;
  localparam logic [2:0] HDR_LAST   = 3'd7;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_CONTENT = 2'd1,
    PH_PADDING = 2'd2
  } parse_phase_t;

  logic       clk;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic       m_axis_tlast;

  fastcgi_response_deframer uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  logic [7:0] pending_bytes[$];
  event_t     expected_events[$];

  // parser state mirrored by the predictor
  parse_phase_t prs_phase;
  logic [2:0]   prs_hdr_idx;
  logic [7:0]   prs_type;
  logic [7:0]   prs_len_hi;
  logic [15:0]  prs_len;
  logic [15:0]  prs_pos;
  logic [7:0]   prs_pad;

  int total_bytes;
  int bytes_taken;
  int results_checked;
  int fail_count;
  int cycle_count;
  int n_stdout;
  int n_stderr;
  int n_end;
  int n_other;

  logic in_fire;
  int   burst_left;
  int   gap_left;
  int   ready_mode;
  int   ready_hold;

  function automatic void parse_byte(input logic [7:0] b);
    logic   last_byte;
    event_t ev;
    case (prs_phase)
      PH_CONTENT: begin
        last_byte = ({16'd0, prs_pos} + 32'd1) == {16'd0, prs_len};
        if (prs_type == TYPE_STDOUT || prs_type == TYPE_STDERR) begin
          ev.kind = (prs_type == TYPE_STDOUT) ? KIND_STDOUT : KIND_STDERR;
          ev.data = b;
          ev.last_of_record = last_byte;
          expected_events.push_back(ev);
        end else if (prs_type == TYPE_END_REQUEST && prs_pos == STATUS_OFFSET) begin
          ev.kind = KIND_END;
          ev.data = b;
          ev.last_of_record = 1'b0;
          expected_events.push_back(ev);
        end
        prs_pos = prs_pos + 16'd1;
        if (last_byte) prs_phase = (prs_pad != 8'd0) ? PH_PADDING : PH_HEADER;
      end
      PH_PADDING: begin
        prs_pad = prs_pad - 8'd1;
        if (prs_pad == 8'd0) prs_phase = PH_HEADER;
      end
      default: begin
        case (prs_hdr_idx)
          HDR_TYPE:   prs_type = b;
          HDR_LEN_HI: prs_len_hi = b;
          HDR_LEN_LO: prs_len = {prs_len_hi, b};
          HDR_PAD:    prs_pad = b;
          default: ;
        endcase
        if (prs_hdr_idx == HDR_LAST) begin
          prs_hdr_idx = 3'd0;
          prs_pos = 16'd0;
          if (prs_len != 16'd0) prs_phase = PH_CONTENT;
          else prs_phase = (prs_pad != 8'd0) ? PH_PADDING : PH_HEADER;
        end else begin
          prs_hdr_idx = prs_hdr_idx + 3'd1;
          prs_phase = PH_HEADER;
        end
      end
    endcase
  endfunction

  function automatic void push_header(input logic [7:0] rtype, input logic [15:0] clen,
                                      input logic [7:0] plen);
    pending_bytes.push_back(8'($urandom_range(0, 255)));  // version, ignored
    pending_bytes.push_back(rtype);
    pending_bytes.push_back(8'($urandom_range(0, 255)));  // request id
    pending_bytes.push_back(8'($urandom_range(0, 255)));
    pending_bytes.push_back(clen[15:8]);
    pending_bytes.push_back(clen[7:0]);
    pending_bytes.push_back(plen);
    pending_bytes.push_back(8'($urandom_range(0, 255)));  // reserved
    if (rtype == TYPE_STDOUT) n_stdout++;
    else if (rtype == TYPE_STDERR) n_stderr++;
    else if (rtype == TYPE_END_REQUEST) n_end++;
    else n_other++;
  endfunction

  function automatic void add_random_record();
    int         pick;
    logic [7:0] rtype;
    int         clen;
    int         plen;
    pick = $urandom_range(0, 99);
    if (pick < 35) rtype = TYPE_STDOUT;
    else if (pick < 60) rtype = TYPE_STDERR;
    else if (pick < 80) rtype = TYPE_END_REQUEST;
    else rtype = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (rtype == TYPE_END_REQUEST) begin
      // mostly the normal 8-byte body, some short ones (only a 5-byte one reaches the status byte), some long ones
      if (pick < 65) clen = 8;
      else if (pick < 90) clen = $urandom_range(0, 5);
      else clen = $urandom_range(6, 40);
    end else if (pick < 10) clen = 0;
    else if (pick < 16) clen = 1;
    else if (pick < 80) clen = $urandom_range(2, 16);
    else if (pick < 96) clen = $urandom_range(17, 64);
    else clen = $urandom_range(250, 300);
    pick = $urandom_range(0, 99);
    if (pick < 40) plen = 0;
    else if (pick < 96) plen = $urandom_range(1, 7);
    else plen = $urandom_range(8, 255);
    push_header(rtype, 16'(clen), 8'(plen));
    repeat (clen + plen) pending_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sender: bursts of beats with random gaps
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (gap_left > 0 || pending_bytes.size() == 0) begin
        s_axis_tvalid <= 1'b0;
        if (gap_left > 0) gap_left = gap_left - 1;
      end else begin
        s_axis_tdata <= pending_bytes.pop_front();
        s_axis_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 48);
          case ($urandom_range(0, 9))
            0, 1, 2: gap_left = 0;
            9:       gap_left = $urandom_range(8, 20);
            default: gap_left = $urandom_range(1, 4);
          endcase
        end else begin
          burst_left = burst_left - 1;
        end
      end
    end
  end

  // receiver: stall pattern switches between modes after a random hold
  always @(negedge clk) begin
    if (ready_hold == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_hold = $urandom_range(8, 64);
    end
    ready_hold = ready_hold - 1;
    case (ready_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= ($urandom_range(0, 7) == 0);
      default: m_axis_tready <= (ready_hold % 12 == 0);
    endcase
  end

  always @(posedge clk) begin
    in_fire <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_events.size() == 0) begin
        $error("unexpected result beat: kind %0d data %0h last_of_record %0b",
               m_axis_tuser, m_axis_tdata, m_axis_tlast);
        fail_count = fail_count + 1;
      end else begin
        event_t ev;
        ev = expected_events.pop_front();
        if (m_axis_tuser != ev.kind) begin
          $error("kind mismatch: expected %0d, actual %0d", ev.kind, m_axis_tuser);
          fail_count = fail_count + 1;
        end
        if (m_axis_tdata != ev.data) begin
          $error("data mismatch: expected %0h, actual %0h", ev.data, m_axis_tdata);
          fail_count = fail_count + 1;
        end
        if (m_axis_tlast != ev.last_of_record) begin
          $error("last_of_record mismatch: expected %0b, actual %0b",
                 ev.last_of_record, m_axis_tlast);
          fail_count = fail_count + 1;
        end
        results_checked <= results_checked + 1;
      end
    end
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      parse_byte(s_axis_tdata);
      bytes_taken <= bytes_taken + 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TIMEOUT_CYCLES) begin
      $display("tb_fastcgi_response_deframer failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'd0;
    m_axis_tready = 1'b0;
    in_fire = 1'b0;
    burst_left = 0;
    gap_left = 0;
    ready_mode = 0;
    ready_hold = 0;
    bytes_taken = 0;
    results_checked = 0;
    fail_count = 0;
    cycle_count = 0;
    n_stdout = 0;
    n_stderr = 0;
    n_end = 0;
    n_other = 0;
    prs_phase = PH_HEADER;
    prs_hdr_idx = 3'd0;
    prs_type = 8'd0;
    prs_len_hi = 8'd0;
    prs_len = 16'd0;
    prs_pos = 16'd0;
    prs_pad = 8'd0;

    // one-byte stdout record at the top byte value
    push_header(TYPE_STDOUT, 16'd1, 8'd0);
    pending_bytes.push_back(8'hFF);
    // empty stderr body that still has padding
    push_header(TYPE_STDERR, 16'd0, 8'd1);
    pending_bytes.push_back(8'h00);
    // end of request with the status byte at the top value
    push_header(TYPE_END_REQUEST, 16'd5, 8'd0);
    repeat (4) pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'hFF);

    while (pending_bytes.size() < RANDOM_BYTES) add_random_record();
    total_bytes = pending_bytes.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (bytes_taken < total_bytes) @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d bytes in %0d records: %0d stdout, %0d stderr, %0d end request, %0d other",
             total_bytes, n_stdout + n_stderr + n_end + n_other, n_stdout, n_stderr, n_end,
             n_other);
    $display("checked %0d result beats against the predicted stream", results_checked);
    if (fail_count == 0) begin
      $display("tb_fastcgi_response_deframer passed");
    end else begin
      $display("tb_fastcgi_response_deframer failed");
    end
    $finish;
  end

endmodule
